FILE: rtl/sdt_pkg.sv
// Shared types, constants and codes for the switch debounce and throttle block.
// Used by sdt_judge and switch_debounce_throttle; depends on nothing.
`timescale 1ns / 1ps

package sdt_pkg;

  // Number of matrix switches that have per-switch state.
  localparam int unsigned NUM_SWITCHES = 64;
  localparam int unsigned SW_IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  // Field widths fixed by the interface.
  localparam int unsigned SW_W    = 7;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Timing registers count in 100 us units.
  localparam int unsigned UNIT_US = 100;
  localparam int unsigned THR_W   = $clog2(((1 << CFG_W) - 1) * UNIT_US + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_TIME = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_REJECT   = 2'd1,
    VERDICT_THROTTLE = 2'd2
  } verdict_t;

  // One switch's stored state.
  typedef struct packed {
    logic              throttle_flag;
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] change_stamp;
  } entry_t;

  // Thresholds already scaled to microseconds.
  typedef struct packed {
    logic [THR_W-1:0] press;
    logic [THR_W-1:0] release_thr;
    logic [THR_W-1:0] throttle;
  } thr_t;

endpackage

FILE: rtl/sdt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the per-switch state store.
`timescale 1ns / 1ps

module sdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sdt_judge.sv
// Per-event decision logic: edge debounce followed by the press throttle.
// Depends on sdt_pkg for the entry, threshold and verdict types.
`timescale 1ns / 1ps

module sdt_judge (
  input  logic                      pressed,
  input  logic [sdt_pkg::TIME_W-1:0] now_us,
  input  sdt_pkg::thr_t             thr,
  input  sdt_pkg::entry_t           cur,
  output sdt_pkg::entry_t           nxt,
  output sdt_pkg::verdict_t         verdict
);

  logic [sdt_pkg::TIME_W-1:0] since_change;
  logic [sdt_pkg::TIME_W-1:0] since_press;

  assign since_change = now_us - cur.change_stamp;
  assign since_press  = now_us - cur.press_stamp;

  always_comb begin
    nxt     = cur;
    verdict = sdt_pkg::VERDICT_PASS;
    if (pressed) begin
      if (since_change < sdt_pkg::TIME_W'(thr.press)) begin
        // A bouncing press restarts the stable-time window.
        nxt.change_stamp = now_us;
        verdict          = sdt_pkg::VERDICT_REJECT;
      end else if (since_press < sdt_pkg::TIME_W'(thr.throttle)) begin
        nxt.throttle_flag = 1'b1;
        verdict           = sdt_pkg::VERDICT_THROTTLE;
      end else begin
        nxt.press_stamp = now_us;
      end
    end else begin
      if (since_change < sdt_pkg::TIME_W'(thr.release_thr)) begin
        verdict = sdt_pkg::VERDICT_REJECT;
      end else if (cur.throttle_flag) begin
        // The release that matches a throttled press is swallowed too.
        nxt.throttle_flag = 1'b0;
        verdict           = sdt_pkg::VERDICT_THROTTLE;
      end
    end
  end

endmodule

FILE: rtl/switch_debounce_throttle.sv
// Top level of the switch-matrix event debouncer and press throttle.
// Depends on sdt_pkg, sdt_ram and sdt_judge.
`timescale 1ns / 1ps

// Usage
// Each input item is one switch edge: a switch number from one, a press or
// release flag, and a free-running microsecond timestamp. Every input item
// yields exactly one result item that echoes the switch and edge kind and
// carries a verdict: passed, rejected (by the edge debounce or for an
// out-of-range switch), or suppressed by the throttle. Both channels use valid
// and stall; an item moves at a clock edge where valid is high and stall is low.
// The three timing registers are written through the cfg port in 100 us units
// and are scaled to microseconds when written. Write them only while idle.
// An accepted item passes through the decision stage register and then the
// result register. Throughput is one item per cycle while the receiver does
// not stall, set by the single read of the per-switch state RAM at accept and
// its write-back as the item leaves the decision stage; a write-back register
// forwards state to a following item of the same switch.
// Reset clears the timing registers, the pipeline and the per-entry valid
// bits; an entry never written since reset reads as all zero, so no clearing
// pass is needed. When the receiver stalls, the result register holds and
// one more item can still be taken into the decision stage; only then does
// in_stall rise.

module switch_debounce_throttle (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [sdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdt_pkg::CFG_W-1:0]     cfg_data,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sdt_pkg::SW_W-1:0]      in_switch_number,
  input  logic                          in_pressed,
  input  logic [sdt_pkg::TIME_W-1:0]    in_now_us,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdt_pkg::SW_W-1:0]      out_switch_out,
  output logic                          out_pressed_out,
  output logic [1:0]                    out_verdict
);

  // Thresholds in microseconds.
  sdt_pkg::thr_t thr_r;

  // Decision stage register.
  logic                            s1_valid_r;
  logic [sdt_pkg::SW_W-1:0]        s1_sw_r;
  logic                            s1_pressed_r;
  logic [sdt_pkg::TIME_W-1:0]      s1_now_r;
  logic [sdt_pkg::SW_IDX_W-1:0]    s1_idx_r;
  logic                            s1_in_range_r;

  // Result register.
  logic                            out_valid_r;
  logic [sdt_pkg::SW_W-1:0]        out_sw_r;
  logic                            out_pressed_r;
  sdt_pkg::verdict_t               out_verdict_r;

  // Per-entry valid bits and the last write, kept for forwarding.
  logic [sdt_pkg::NUM_SWITCHES-1:0] valid_r;
  logic                             fwd_valid_r;
  logic [sdt_pkg::SW_IDX_W-1:0]     fwd_idx_r;
  sdt_pkg::entry_t                  fwd_entry_r;

  logic                            in_accept;
  logic                            out_load;
  logic [sdt_pkg::SW_IDX_W-1:0]    in_idx;
  logic                            in_range;
  logic                            ram_we;
  sdt_pkg::entry_t                 ram_rdata;
  sdt_pkg::entry_t                 cur_entry;
  sdt_pkg::entry_t                 nxt_entry;
  sdt_pkg::verdict_t               judge_verdict;
  sdt_pkg::verdict_t               final_verdict;
  logic [sdt_pkg::THR_W-1:0]       cfg_scaled;

  // Handshake. The decision stage empties whenever the result register is
  // free or being taken.
  assign out_load  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  // Switches are numbered from one; zero and anything above the switch count
  // are out of range and touch no state.
  assign in_range = (in_switch_number != '0) &&
                    (32'(in_switch_number) <= sdt_pkg::NUM_SWITCHES);
  assign in_idx   = sdt_pkg::SW_IDX_W'(32'(in_switch_number) - 32'd1);

  assign cfg_scaled = sdt_pkg::THR_W'(32'(cfg_data) * sdt_pkg::UNIT_US);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdt_pkg::REG_PRESS_TIME:    thr_r.press       <= cfg_scaled;
        sdt_pkg::REG_RELEASE_TIME:  thr_r.release_thr <= cfg_scaled;
        sdt_pkg::REG_THROTTLE_TIME: thr_r.throttle    <= cfg_scaled;
        default: begin
        end
      endcase
    end
  end

  // State store, read when an item is accepted.
  sdt_ram #(
    .WIDTH ($bits(sdt_pkg::entry_t)),
    .DEPTH (sdt_pkg::NUM_SWITCHES)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (nxt_entry),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // The write of the item ahead lands on the same edge as this item's read,
  // so the RAM returns the older value; the forwarding register covers it.
  always_comb begin
    if (fwd_valid_r && (fwd_idx_r == s1_idx_r)) begin
      cur_entry = fwd_entry_r;
    end else if (valid_r[s1_idx_r]) begin
      cur_entry = ram_rdata;
    end else begin
      cur_entry = '0;
    end
  end

  sdt_judge u_judge (
    .pressed (s1_pressed_r),
    .now_us  (s1_now_r),
    .thr     (thr_r),
    .cur     (cur_entry),
    .nxt     (nxt_entry),
    .verdict (judge_verdict)
  );

  assign final_verdict = s1_in_range_r ? judge_verdict : sdt_pkg::VERDICT_REJECT;
  assign ram_we        = out_load && s1_in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        valid_r[s1_idx_r] <= 1'b1;
        fwd_valid_r       <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sw_r       <= in_switch_number;
      s1_pressed_r  <= in_pressed;
      s1_now_r      <= in_now_us;
      s1_idx_r      <= in_idx;
      s1_in_range_r <= in_range;
    end
    if (out_load) begin
      out_sw_r      <= s1_sw_r;
      out_pressed_r <= s1_pressed_r;
      out_verdict_r <= final_verdict;
    end
    if (ram_we) begin
      fwd_idx_r   <= s1_idx_r;
      fwd_entry_r <= nxt_entry;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_switch_out  = out_sw_r;
  assign out_pressed_out = out_pressed_r;
  assign out_verdict     = out_verdict_r;

  // A rejected press must restart its stable-time window at the event time.
  a_reject_restamps: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && s1_pressed_r && (judge_verdict == sdt_pkg::VERDICT_REJECT)
    |-> nxt_entry.change_stamp == s1_now_r)
    else $error("rejected press did not restamp its switch");

  // Releases never move either stamp.
  a_release_keeps_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && !s1_pressed_r
    |-> (nxt_entry.press_stamp == cur_entry.press_stamp) &&
        (nxt_entry.change_stamp == cur_entry.change_stamp))
    else $error("release changed a stamp");

  // Once written, an entry stays valid.
  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(s1_idx_r)])
    else $error("written entry not marked valid");

  // Out-of-range switch numbers come out rejected.
  a_range_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !s1_in_range_r |=> out_verdict == sdt_pkg::VERDICT_REJECT)
    else $error("out-of-range switch not rejected");

endmodule
